>>> src/dtt_pkg.sv
// Shared types, constants and helpers for the dominance transposition table.
package dtt_pkg;

    localparam int DEF_BUCKETS = 1024;
    localparam int DEF_WAYS    = 8;

    localparam logic       KIND_LOAD  = 1'b0;
    localparam logic       KIND_STORE = 1'b1;
    localparam logic [7:0] GEN_RESET  = 8'd1;
    localparam logic [20:0] PN_MISS   = 21'd1;

    typedef struct packed {
        logic        kind;
        logic [63:0] board_hash;
        logic [11:0] depth;
        logic [4:0]  hand_pawns;
        logic [2:0]  hand_lances;
        logic [2:0]  hand_knights;
        logic [2:0]  hand_silvers;
        logic [2:0]  hand_golds;
        logic [1:0]  hand_bishops;
        logic [1:0]  hand_rooks;
        logic [20:0] proof_in;
        logic [20:0] disproof_in;
    } in_item_t;

    typedef struct packed {
        logic [20:0] proof_out;
        logic [20:0] disproof_out;
        logic        found;
    } out_item_t;

    typedef struct packed {
        logic [1:0] rooks;
        logic [1:0] bishops;
        logic [2:0] golds;
        logic [2:0] silvers;
        logic [2:0] knights;
        logic [2:0] lances;
        logic [4:0] pawns;
    } hand_t;

    typedef struct packed {
        logic [63:0] hash;
        hand_t       hand;
        logic [20:0] proof;
        logic [20:0] disproof;
    } slot_t;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } mem_ctl_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_HASH,
        ST_EVAL
    } state_t;

    // every count of a is >= the matching count of b
    function automatic logic dominates(hand_t a, hand_t b);
        return (a.pawns >= b.pawns) && (a.lances >= b.lances) &&
               (a.knights >= b.knights) && (a.silvers >= b.silvers) &&
               (a.golds >= b.golds) && (a.bishops >= b.bishops) &&
               (a.rooks >= b.rooks);
    endfunction

    function automatic hand_t hand_of(in_item_t it);
        hand_t h;
        h.pawns   = it.hand_pawns;
        h.lances  = it.hand_lances;
        h.knights = it.hand_knights;
        h.silvers = it.hand_silvers;
        h.golds   = it.hand_golds;
        h.bishops = it.hand_bishops;
        h.rooks   = it.hand_rooks;
        return h;
    endfunction

endpackage

>>> src/dtt_bucket_mod.sv
// Bucket index unit: 64-bit sum reduced modulo the bucket count.
module dtt_bucket_mod #(
    parameter int BUCKETS = dtt_pkg::DEF_BUCKETS,
    localparam int IDX_W = (BUCKETS > 1) ? $clog2(BUCKETS) : 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [63:0]       sum,
    output logic              done,
    output logic [IDX_W-1:0]  bucket
);

    localparam bit POW2 = ((BUCKETS & (BUCKETS - 1)) == 0);

    generate
        if (POW2)
        begin : g_mask
            logic             done_reg;
            logic [IDX_W-1:0] bucket_reg;

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    done_reg <= 1'b0;
                end
                else
                begin
                    done_reg <= start;
                end
            end

            always_ff @(posedge clk)
            begin
                if (start)
                begin
                    bucket_reg <= sum[IDX_W-1:0] & IDX_W'(BUCKETS - 1);
                end
            end

            assign done   = done_reg;
            assign bucket = bucket_reg;
        end
        else
        begin : g_iter
            // four bits of the sum per cycle, MSB first: r = (2r + b) mod BUCKETS
            localparam int MW = IDX_W + 1;
            localparam logic [MW-1:0] MODV = MW'(BUCKETS);

            logic             busy_reg;
            logic             done_reg;
            logic [3:0]       cnt_reg;
            logic [63:0]      sum_reg;
            logic [IDX_W-1:0] r_reg;
            logic [IDX_W-1:0] r_step;

            always_comb
            begin
                logic [IDX_W-1:0] t;
                logic [MW-1:0]    x;
                t = r_reg;
                for (int k = 0; k < 4; k++)
                begin
                    x = {t, sum_reg[63 - k]};
                    if (x >= MODV)
                    begin
                        x = x - MODV;
                    end
                    t = x[IDX_W-1:0];
                end
                r_step = t;
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b0;
                    cnt_reg  <= '0;
                end
                else if (start)
                begin
                    busy_reg <= 1'b1;
                    done_reg <= 1'b0;
                    cnt_reg  <= '0;
                end
                else if (busy_reg)
                begin
                    cnt_reg <= cnt_reg + 4'd1;
                    if (cnt_reg == 4'hF)
                    begin
                        busy_reg <= 1'b0;
                        done_reg <= 1'b1;
                    end
                end
                else
                begin
                    done_reg <= 1'b0;
                end
            end

            always_ff @(posedge clk)
            begin
                if (start)
                begin
                    sum_reg <= sum;
                    r_reg   <= '0;
                end
                else if (busy_reg)
                begin
                    sum_reg <= {sum_reg[59:0], 4'h0};
                    r_reg   <= r_step;
                end
            end

            assign done   = done_reg;
            assign bucket = r_reg;
        end
    endgenerate

endmodule

>>> src/dtt_slot_mem.sv
// Bucket memories: slot data and per-way generation tags, with the tags cleared after reset.
module dtt_slot_mem #(
    parameter int BUCKETS = dtt_pkg::DEF_BUCKETS,
    parameter int WAYS    = dtt_pkg::DEF_WAYS,
    localparam int IDX_W = (BUCKETS > 1) ? $clog2(BUCKETS) : 1
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  dtt_pkg::mem_ctl_t           ctl,
    input  logic [IDX_W-1:0]            addr,
    input  dtt_pkg::slot_t [WAYS-1:0]   wr_row,
    input  logic [WAYS-1:0][7:0]        wr_gen,
    output dtt_pkg::slot_t [WAYS-1:0]   rd_row,
    output logic [WAYS-1:0][7:0]        rd_gen,
    output logic                        clear_done
);

    import dtt_pkg::*;

    slot_t [WAYS-1:0]     data_mem [BUCKETS];
    logic [WAYS-1:0][7:0] gen_mem  [BUCKETS];

    logic                 clr_busy_reg;
    logic [IDX_W-1:0]     clr_cnt_reg;
    logic                 gen_we;
    logic [IDX_W-1:0]     gen_addr;
    logic [WAYS-1:0][7:0] gen_wdata;
    slot_t [WAYS-1:0]     rd_row_reg;
    logic [WAYS-1:0][7:0] rd_gen_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_cnt_reg  <= '0;
        end
        else if (clr_busy_reg)
        begin
            clr_cnt_reg <= clr_cnt_reg + IDX_W'(1);
            if (clr_cnt_reg == IDX_W'(BUCKETS - 1))
            begin
                clr_busy_reg <= 1'b0;
            end
        end
    end

    assign clear_done = !clr_busy_reg;
    assign gen_we     = clr_busy_reg || ctl.wr_en;
    assign gen_addr   = clr_busy_reg ? clr_cnt_reg : addr;
    assign gen_wdata  = clr_busy_reg ? '0 : wr_gen;

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            data_mem[addr] <= wr_row;
        end
        if (ctl.rd_en)
        begin
            rd_row_reg <= data_mem[addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (gen_we)
        begin
            gen_mem[gen_addr] <= gen_wdata;
        end
        if (ctl.rd_en)
        begin
            rd_gen_reg <= gen_mem[addr];
        end
    end

    assign rd_row = rd_row_reg;
    assign rd_gen = rd_gen_reg;

endmodule

>>> src/dtt_bucket_eval.sv
// Way compare and select: store row update and load result for one bucket.
module dtt_bucket_eval #(
    parameter int WAYS = dtt_pkg::DEF_WAYS
) (
    input  dtt_pkg::in_item_t           item,
    input  logic [7:0]                  cur_gen,
    input  dtt_pkg::slot_t [WAYS-1:0]   rd_row,
    input  logic [WAYS-1:0][7:0]        rd_gen,
    output dtt_pkg::slot_t [WAYS-1:0]   wr_row,
    output logic [WAYS-1:0][7:0]        wr_gen,
    output dtt_pkg::out_item_t          result
);

    import dtt_pkg::*;

    hand_t           hand;
    slot_t           new_slot;
    logic [WAYS-1:0] st_first;
    logic [WAYS-1:0] ld_first;

    assign hand              = hand_of(item);
    assign new_slot.hash     = item.board_hash;
    assign new_slot.hand     = hand;
    assign new_slot.proof    = item.proof_in;
    assign new_slot.disproof = item.disproof_in;

    always_comb
    begin
        logic live;
        logic hm;
        logic heq;
        logic st_term;
        logic ld_hit;
        logic st_seen;
        logic ld_seen;
        logic live_pre;
        st_seen  = 1'b0;
        ld_seen  = 1'b0;
        live_pre = 1'b1;
        st_first = '0;
        ld_first = '0;
        for (int w = 0; w < WAYS; w++)
        begin
            live     = (rd_gen[w] == cur_gen);
            hm       = (rd_row[w].hash == item.board_hash);
            heq      = (rd_row[w].hand == hand);
            live_pre = live_pre && live;
            st_term  = !live || (w == WAYS - 1) ||
                       (hm && (((item.proof_in == '0) && dominates(rd_row[w].hand, hand))
                               || heq));
            ld_hit   = live_pre && hm &&
                       (((rd_row[w].proof == '0) && dominates(hand, rd_row[w].hand)) || heq);
            st_first[w] = st_term && !st_seen;
            ld_first[w] = ld_hit && !ld_seen;
            st_seen  = st_seen || st_term;
            ld_seen  = ld_seen || ld_hit;
        end
    end

    // every store outcome leaves the chosen slot holding the new item and live tag
    always_comb
    begin
        for (int w = 0; w < WAYS; w++)
        begin
            wr_row[w] = st_first[w] ? new_slot : rd_row[w];
            wr_gen[w] = st_first[w] ? cur_gen : rd_gen[w];
        end
    end

    always_comb
    begin
        logic [20:0] pn;
        logic [20:0] dn;
        pn = '0;
        dn = '0;
        for (int w = 0; w < WAYS; w++)
        begin
            pn = pn | (rd_row[w].proof & {21{ld_first[w]}});
            dn = dn | (rd_row[w].disproof & {21{ld_first[w]}});
        end
        result.found        = |ld_first;
        result.proof_out    = result.found ? pn : PN_MISS;
        result.disproof_out = result.found ? dn : PN_MISS;
    end

endmodule

>>> src/dominance_transposition_table.sv
// Top level of the dominance transposition table.
//
// Input channel in_valid/in_ready/in_data carries load and store transactions;
// output channel out_valid/out_ready/out_data returns one result per load, none
// per store. cfg_wr_en/cfg_wr_data write current_generation (reset value 1).
// One transaction at a time: accept, bucket index, bucket memory read, then
// compare of all ways from one wide row and write-back of the row for a store.
// With BUCKETS a power of two the bucket index is a masked copy of the sum;
// otherwise the modulo unit reduces four bits of the 64-bit sum per cycle.
// A load result is held in an output register; the next transaction is accepted
// while it waits. If the receiver stalls and a second load result is ready, the
// block holds that load until the output register frees.
// After reset in_ready stays low while the generation memory is cleared one
// bucket row per cycle; configuration writes are taken.
module dominance_transposition_table #(
    parameter int BUCKETS = dtt_pkg::DEF_BUCKETS,
    parameter int WAYS    = dtt_pkg::DEF_WAYS
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  dtt_pkg::in_item_t   in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output dtt_pkg::out_item_t  out_data,
    input  logic                cfg_wr_en,
    input  logic [7:0]          cfg_wr_data
);

    import dtt_pkg::*;

    localparam int IDX_W = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;

    state_t               state_reg;
    state_t               state_next;
    logic [7:0]           gen_reg;
    in_item_t             item_reg;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    out_item_t            out_data_reg;

    logic                 accept;
    logic                 clear_done;
    logic                 mod_done;
    logic [IDX_W-1:0]     bucket;
    logic                 eval_done;
    logic                 out_load;
    mem_ctl_t             mem_ctl;
    slot_t [WAYS-1:0]     rd_row;
    slot_t [WAYS-1:0]     wr_row;
    logic [WAYS-1:0][7:0] rd_gen;
    logic [WAYS-1:0][7:0] wr_gen;
    out_item_t            result;

    assign accept = in_valid && in_ready;

    dtt_bucket_mod #(
        .BUCKETS (BUCKETS)
    ) u_mod (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (accept),
        .sum    (in_data.board_hash + 64'(in_data.depth)),
        .done   (mod_done),
        .bucket (bucket)
    );

    dtt_slot_mem #(
        .BUCKETS (BUCKETS),
        .WAYS    (WAYS)
    ) u_mem (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (mem_ctl),
        .addr       (bucket),
        .wr_row     (wr_row),
        .wr_gen     (wr_gen),
        .rd_row     (rd_row),
        .rd_gen     (rd_gen),
        .clear_done (clear_done)
    );

    dtt_bucket_eval #(
        .WAYS (WAYS)
    ) u_eval (
        .item    (item_reg),
        .cur_gen (gen_reg),
        .rd_row  (rd_row),
        .rd_gen  (rd_gen),
        .wr_row  (wr_row),
        .wr_gen  (wr_gen),
        .result  (result)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_HASH;
                end
            end
            ST_HASH:
            begin
                if (mod_done)
                begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                if ((item_reg.kind == KIND_STORE) || !out_valid_reg || out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready      = 1'b0;
        mem_ctl.rd_en = 1'b0;
        eval_done     = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = clear_done;
            end
            ST_HASH:
            begin
                mem_ctl.rd_en = mod_done;
            end
            ST_EVAL:
            begin
                eval_done = (item_reg.kind == KIND_STORE) || !out_valid_reg || out_ready;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
        mem_ctl.wr_en = eval_done && (item_reg.kind == KIND_STORE);
        out_load      = eval_done && (item_reg.kind == KIND_LOAD);
    end

    always_comb
    begin
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            gen_reg       <= GEN_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                gen_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= in_data;
        end
        if (out_load)
        begin
            out_data_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

>>> tb/sv/testbench.sv
// Self-checking testbench for dominance_transposition_table against a table predictor.
module testbench;
    import dtt_pkg::*;

    localparam int N_BUCKETS    = DEF_BUCKETS;
    localparam int N_WAYS       = DEF_WAYS;
    localparam int N_SLOTS      = N_BUCKETS * N_WAYS;
    localparam int BUCKET_BITS  = $clog2(N_BUCKETS);
    localparam int RESET_CYCLES = 11;
    localparam int DRAIN_CYCLES = 24;
    localparam int HOLD_CYCLES  = 300;
    localparam int QUIET_LIMIT  = 6000;

    typedef enum int {
        HAND_FRESH,
        HAND_BELOW,
        HAND_ABOVE,
        HAND_WIDE
    } hand_shape_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    in_item_t    in_data = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    out_item_t   out_data;
    logic        cfg_wr_en = 1'b0;
    logic [7:0]  cfg_wr_data = '0;

    // predicted table contents
    logic [63:0] tt_hash     [N_SLOTS];
    hand_t       tt_hand     [N_SLOTS];
    logic [20:0] tt_proof    [N_SLOTS];
    logic [20:0] tt_disproof [N_SLOTS];
    logic [7:0]  tt_gen      [N_SLOTS];
    logic [7:0]  live_gen;

    out_item_t   lookup_results_due [$];
    out_item_t   due;
    int          error_count = 0;
    int          quiet_cycles = 0;

    // traffic shaping
    logic [63:0] key_hash  [$];
    logic [11:0] key_depth [$];
    hand_t       hand_set  [4];
    bit          tx_gaps = 1'b1;
    bit          rx_stalls = 1'b1;
    int          hold_request = 0;
    int          stall_left = 0;

    dominance_transposition_table dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_data    (out_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always #1 clk = ~clk;

    function automatic hand_t hand_from_txn(input in_item_t t);
        hand_t h;
        h.pawns   = t.hand_pawns;
        h.lances  = t.hand_lances;
        h.knights = t.hand_knights;
        h.silvers = t.hand_silvers;
        h.golds   = t.hand_golds;
        h.bishops = t.hand_bishops;
        h.rooks   = t.hand_rooks;
        return h;
    endfunction

    function automatic logic holds_at_least(input hand_t a, input hand_t b);
        return a.pawns >= b.pawns && a.lances >= b.lances && a.knights >= b.knights &&
               a.silvers >= b.silvers && a.golds >= b.golds &&
               a.bishops >= b.bishops && a.rooks >= b.rooks;
    endfunction

    // applies one accepted transaction to the predicted table
    function automatic void table_access(input in_item_t t);
        hand_t       h;
        logic [63:0] sum;
        int          base;
        int          s;
        out_item_t   res;
        h    = hand_from_txn(t);
        sum  = t.board_hash + 64'(t.depth);
        base = int'(sum % 64'(N_BUCKETS)) * N_WAYS;
        if (t.kind == KIND_STORE)
        begin
            for (int w = 0; w < N_WAYS; w++)
            begin
                s = base + w;
                if (tt_gen[s] != live_gen || w == N_WAYS - 1)
                begin
                    tt_hash[s]     = t.board_hash;
                    tt_hand[s]     = h;
                    tt_proof[s]    = t.proof_in;
                    tt_disproof[s] = t.disproof_in;
                    tt_gen[s]      = live_gen;
                    return;
                end
                if (tt_hash[s] == t.board_hash)
                begin
                    if (t.proof_in == '0 && holds_at_least(tt_hand[s], h))
                    begin
                        tt_hand[s]     = h;
                        tt_proof[s]    = t.proof_in;
                        tt_disproof[s] = t.disproof_in;
                        return;
                    end
                    if (tt_hand[s] == h)
                    begin
                        tt_proof[s]    = t.proof_in;
                        tt_disproof[s] = t.disproof_in;
                        return;
                    end
                end
            end
        end
        else
        begin
            res.proof_out    = PN_MISS;
            res.disproof_out = PN_MISS;
            res.found        = 1'b0;
            for (int w = 0; w < N_WAYS; w++)
            begin
                s = base + w;
                if (tt_gen[s] != live_gen)
                    break;
                if (tt_hash[s] == t.board_hash &&
                    ((tt_proof[s] == '0 && holds_at_least(h, tt_hand[s])) || tt_hand[s] == h))
                begin
                    res.proof_out    = tt_proof[s];
                    res.disproof_out = tt_disproof[s];
                    res.found        = 1'b1;
                    break;
                end
            end
            lookup_results_due.push_back(res);
        end
    endfunction

    task automatic report(input string what, input logic [63:0] want, input logic [63:0] got);
        error_count++;
        $display("%0t: %s mismatch: expected %0d, got %0d", $time, what, want, got);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
            table_access(in_data);
        if (rst_n && out_valid && out_ready)
        begin
            if (lookup_results_due.size() == 0)
            begin
                error_count++;
                $display("%0t: unexpected result: expected none, got %0d %0d %0b",
                         $time, out_data.proof_out, out_data.disproof_out, out_data.found);
            end
            else
            begin
                due = lookup_results_due.pop_front();
                if (out_data.proof_out !== due.proof_out)
                    report("proof_out", 64'(due.proof_out), 64'(out_data.proof_out));
                if (out_data.disproof_out !== due.disproof_out)
                    report("disproof_out", 64'(due.disproof_out), 64'(out_data.disproof_out));
                if (out_data.found !== due.found)
                    report("found", 64'(due.found), 64'(out_data.found));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic int pick_wait();
        if ($urandom_range(0, 99) < 88)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    always @(posedge clk)
    begin
        if (hold_request > 0)
        begin
            stall_left = hold_request;
            hold_request = 0;
        end
        if (stall_left > 0)
        begin
            out_ready <= 1'b0;
            stall_left--;
        end
        else if (rx_stalls && $urandom_range(0, 99) < 20)
        begin
            stall_left = pick_wait() - 1;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    function automatic int vary_count(input int cur, input int top, input int bits,
                                      input hand_shape_t how);
        case (how)
            HAND_FRESH: return $urandom_range(0, top);
            HAND_BELOW: return $urandom_range(0, cur);
            HAND_ABOVE: return (cur >= top) ? cur : $urandom_range(cur, top);
            default:    return $urandom_range(0, (1 << bits) - 1);
        endcase
    endfunction

    function automatic hand_t vary_hand(input hand_t b, input hand_shape_t how);
        hand_t h;
        h.pawns   = 5'(vary_count(int'(b.pawns), 18, 5, how));
        h.lances  = 3'(vary_count(int'(b.lances), 4, 3, how));
        h.knights = 3'(vary_count(int'(b.knights), 4, 3, how));
        h.silvers = 3'(vary_count(int'(b.silvers), 4, 3, how));
        h.golds   = 3'(vary_count(int'(b.golds), 4, 3, how));
        h.bishops = 2'(vary_count(int'(b.bishops), 2, 2, how));
        h.rooks   = 2'(vary_count(int'(b.rooks), 2, 2, how));
        return h;
    endfunction

    function automatic logic [20:0] pick_pn(input bit zero_often);
        int r;
        r = $urandom_range(0, 99);
        if (zero_often && r < 35)
            return '0;
        if (r < 45)
            return 21'h100000;
        if (r < 50)
            return 21'($urandom);
        if (r < 53)
            return '0;
        return 21'($urandom_range(1, 1000));
    endfunction

    function automatic logic [63:0] hash_for_bucket(input int bucket, input logic [11:0] d);
        logic [63:0] h;
        h = {$urandom, $urandom};
        h[BUCKET_BITS-1:0] = BUCKET_BITS'(bucket) - d[BUCKET_BITS-1:0];
        return h;
    endfunction

    function automatic in_item_t make_txn(input logic kind, input logic [63:0] hash,
                                          input logic [11:0] depth, input hand_t h,
                                          input logic [20:0] pn, input logic [20:0] dn);
        in_item_t t;
        t.kind         = kind;
        t.board_hash   = hash;
        t.depth        = depth;
        t.hand_pawns   = h.pawns;
        t.hand_lances  = h.lances;
        t.hand_knights = h.knights;
        t.hand_silvers = h.silvers;
        t.hand_golds   = h.golds;
        t.hand_bishops = h.bishops;
        t.hand_rooks   = h.rooks;
        t.proof_in     = pn;
        t.disproof_in  = dn;
        return t;
    endfunction

    // mostly hot keys and a small family of related hands; noise hits any bucket
    function automatic in_item_t random_txn(input bit noise_ok);
        int          k;
        logic [63:0] h;
        logic [11:0] d;
        hand_t       hd;
        logic        kind;
        if (noise_ok && $urandom_range(0, 99) < 12)
        begin
            h = {$urandom, $urandom};
            d = 12'($urandom_range(0, 4095));
        end
        else
        begin
            k = $urandom_range(0, key_hash.size() - 1);
            if ($urandom_range(0, 1))
                k = k / 3;
            h = key_hash[k];
            d = key_depth[k];
            if ($urandom_range(0, 9) == 0)
                d[11:10] = 2'($urandom_range(0, 3));
        end
        if ($urandom_range(0, 99) < 88)
            hd = hand_set[$urandom_range(0, 3)];
        else
            hd = vary_hand('0, HAND_WIDE);
        kind = $urandom_range(0, 1) ? KIND_STORE : KIND_LOAD;
        return make_txn(kind, h, d, hd, pick_pn(1'b1), pick_pn(1'b0));
    endfunction

    task automatic reshape_traffic(input int n_buckets, input int per_bucket);
        int          b;
        logic [11:0] d;
        key_hash.delete();
        key_depth.delete();
        repeat (n_buckets)
        begin
            b = $urandom_range(0, N_BUCKETS - 1);
            repeat (per_bucket)
            begin
                d = 12'($urandom_range(0, 4095));
                key_depth.push_back(d);
                key_hash.push_back(hash_for_bucket(b, d));
            end
        end
        hand_set[0] = vary_hand('0, HAND_FRESH);
        hand_set[1] = vary_hand(hand_set[0], HAND_BELOW);
        hand_set[2] = vary_hand(hand_set[0], HAND_ABOVE);
        hand_set[3] = vary_hand(hand_set[1], HAND_ABOVE);
    endtask

    // valid stays high from one transaction to the next unless a gap is drawn
    task automatic send_txn(input in_item_t t);
        int gap;
        gap = (tx_gaps && $urandom_range(0, 99) < 35) ? pick_wait() : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= t;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (lookup_results_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_generation(input logic [7:0] g);
        settle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= g;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        live_gen = g;
    endtask

    task automatic run_mix(input int n, input bit noise_ok);
        repeat (n) send_txn(random_txn(noise_ok));
    endtask

    task automatic test_basic_hits();
        hand_t       hb;
        hand_t       lo;
        hand_t       other;
        logic [63:0] ka;
        logic [11:0] da;
        hb = vary_hand('0, HAND_FRESH);
        hb.pawns = 5'd18;
        hb.rooks = 2'd1;
        lo = vary_hand(hb, HAND_BELOW);
        lo.pawns = 5'd3;
        other = hb;
        other.pawns = 5'd0;
        other.rooks = 2'd2;
        ka = {$urandom, $urandom};
        da = 12'($urandom_range(0, 4095));
        send_txn(make_txn(KIND_LOAD, '0, '0, '0, '0, '0));
        send_txn(make_txn(KIND_STORE, '1, 12'hFFF, '1, '1, 21'h100000));
        send_txn(make_txn(KIND_LOAD, '1, 12'hFFF, '1, '0, '0));
        send_txn(make_txn(KIND_STORE, ka, da, hb, 21'd5, 21'd7));
        send_txn(make_txn(KIND_LOAD, ka, da, hb, '0, '0));
        send_txn(make_txn(KIND_STORE, ka, da, lo, '0, 21'd9));
        send_txn(make_txn(KIND_LOAD, ka, da, lo, '0, '0));
        send_txn(make_txn(KIND_LOAD, ka, da, hb, '0, '0));
        send_txn(make_txn(KIND_STORE, ka, da, other, 21'd3, 21'd4));
        send_txn(make_txn(KIND_LOAD, ka, da, other, '0, '0));
        send_txn(make_txn(KIND_LOAD, ka, da, '0, '0, '0));
        send_txn(make_txn(KIND_LOAD, ka, da ^ 12'h400, hb, '0, '0));
    endtask

    // nine hashes into one bucket: the ninth replaces the last way
    task automatic test_bucket_overflow();
        logic [63:0] h [9];
        logic [11:0] d [9];
        int          b;
        b = $urandom_range(0, N_BUCKETS - 1);
        for (int i = 0; i < 9; i++)
        begin
            d[i] = 12'($urandom_range(0, 4095));
            h[i] = hash_for_bucket(b, d[i]);
            send_txn(make_txn(KIND_STORE, h[i], d[i], '0, 21'(i + 20), 21'(i + 40)));
        end
        send_txn(make_txn(KIND_LOAD, h[7], d[7], '0, '0, '0));
        send_txn(make_txn(KIND_LOAD, h[8], d[8], '0, '0, '0));
        send_txn(make_txn(KIND_LOAD, h[0], d[0], '0, '0, '0));
    endtask

    task automatic test_random_traffic();
        reshape_traffic(6, 6);
        run_mix(450, 1'b1);
    endtask

    task automatic test_generation_sweep();
        set_generation(8'd255);
        reshape_traffic(6, 5);
        run_mix(200, 1'b1);
        set_generation(8'd2);
        run_mix(150, 1'b1);
        set_generation(8'd1);
        run_mix(150, 1'b1);
    endtask

    // generation zero is only used on buckets whose every way has been written
    task automatic test_generation_zero();
        set_generation(8'd200);
        reshape_traffic(4, 8);
        for (int k = 0; k < key_hash.size(); k++)
            send_txn(make_txn(KIND_STORE, key_hash[k], key_depth[k], hand_set[k % 4],
                              pick_pn(1'b1), pick_pn(1'b0)));
        set_generation(8'd0);
        run_mix(200, 1'b0);
        set_generation(8'd1);
    endtask

    task automatic test_output_backpressure();
        in_item_t t;
        reshape_traffic(3, 4);
        run_mix(30, 1'b1);
        hold_request = HOLD_CYCLES;
        repeat (40)
        begin
            t = random_txn(1'b1);
            t.kind = KIND_LOAD;
            send_txn(t);
        end
        settle();
    endtask

    task automatic test_back_to_back();
        tx_gaps = 1'b0;
        rx_stalls = 1'b0;
        reshape_traffic(5, 5);
        run_mix(150, 1'b1);
        settle();
        tx_gaps = 1'b1;
        rx_stalls = 1'b1;
    endtask

    initial
    begin
        foreach (tt_gen[i])
            tt_gen[i] = '0;
        live_gen = GEN_RESET;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        test_basic_hits();
        test_bucket_overflow();
        test_random_traffic();
        test_generation_sweep();
        test_generation_zero();
        test_output_backpressure();
        test_back_to_back();
        settle();
        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
